// ===== rtl/omp_pkg.sv =====
// Shared types and codes for the owned message port mailbox.
`timescale 1ns / 1ps
package omp_pkg;
  localparam logic [2:0] OP_CREATE     = 3'd0;
  localparam logic [2:0] OP_CREATE_ANY = 3'd1;
  localparam logic [2:0] OP_SEND       = 3'd2;
  localparam logic [2:0] OP_RECV       = 3'd3;
  localparam logic [2:0] OP_NOTIFY     = 3'd4;
  localparam logic [2:0] OP_RELEASE    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic        port_ok;
    logic [5:0]  port;
    logic [15:0] pid;
    logic [15:0] msg_from;
    logic [31:0] msg_type;
    logic [7:0]  msg_len;
    logic [63:0] msg_payload;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic rd_wait;
  } bk_stat_t;
endpackage

// ===== rtl/omp_if.sv =====
// Command and result channel interfaces of the mailbox.
`timescale 1ns / 1ps
interface omp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [5:0]  port;
  logic [15:0] pid;
  logic [15:0] msg_from;
  logic [31:0] msg_type;
  logic [7:0]  msg_len;
  logic [63:0] msg_payload;
  modport source(output valid, command, port, pid, msg_from, msg_type, msg_len, msg_payload,
                 input ready);
  modport sink(input valid, command, port, pid, msg_from, msg_type, msg_len, msg_payload,
               output ready);
endinterface

interface omp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  port_id;
  logic [15:0] out_from;
  logic [31:0] out_type;
  logic [7:0]  out_len;
  logic [63:0] out_payload;
  logic [3:0]  queue_count;
  modport source(output valid, status, port_id, out_from, out_type, out_len, out_payload,
                 queue_count, input ready);
  modport sink(input valid, status, port_id, out_from, out_type, out_len, out_payload,
               queue_count, output ready);
endinterface

// ===== rtl/omp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module omp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== rtl/omp_front.sv =====
// Front end: takes command beats, checks the port range and masks the body word.
`timescale 1ns / 1ps
module omp_front #(
  parameter int NUM_PORTS    = 16,
  parameter int PAYLOAD_BITS = 64
) (
  omp_in_if.sink        in_bus,
  input  logic          clearing,
  input  logic          q_full,
  output logic          push,
  output omp_pkg::cmd_t push_data
);
  import omp_pkg::*;

  localparam logic [63:0] PMASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);

  assign in_bus.ready = !q_full && !clearing;
  assign push         = in_bus.valid && in_bus.ready;

  always_comb begin
    push_data.command     = in_bus.command;
    push_data.port_ok     = 7'(in_bus.port) < 7'(NUM_PORTS);
    push_data.port        = in_bus.port;
    push_data.pid         = in_bus.pid;
    push_data.msg_from    = in_bus.msg_from;
    push_data.msg_type    = in_bus.msg_type;
    push_data.msg_len     = in_bus.msg_len;
    push_data.msg_payload = in_bus.msg_payload & PMASK;
  end
endmodule

// ===== rtl/omp_cmd_queue.sv =====
// Two-entry command queue between front end and execution unit.
`timescale 1ns / 1ps
module omp_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  omp_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          valid,
  output omp_pkg::cmd_t head
);
  import omp_pkg::*;

  cmd_t       ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end
endmodule

// ===== rtl/omp_back.sv =====
// Execution unit: port table, message store and result register.
`timescale 1ns / 1ps
module omp_back #(
  parameter int NUM_PORTS    = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  omp_pkg::cmd_t     q_data,
  output logic              q_pop,
  omp_out_if.source         out_bus,
  output omp_pkg::bk_stat_t stat
);
  import omp_pkg::*;

  localparam int PIW   = $clog2(NUM_PORTS);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = 56;

  localparam logic [1:0] S_CLR = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_RDW = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [NUM_PORTS-1:0] live_r, live_nxt;
  logic [15:0]          owner_r [NUM_PORTS];
  logic [PW-1:0]        rptr_r  [NUM_PORTS];
  logic [PW-1:0]        wptr_r  [NUM_PORTS];
  logic [CW-1:0]        cnt_r   [NUM_PORTS];

  logic              ovalid_r, ovalid_nxt;
  logic [1:0]        ostatus_r;
  logic [5:0]        oport_r;
  logic [CW-1:0]     ocnt_r;
  logic [MW-1:0]     ometa_r;
  logic [PAYLOAD_BITS-1:0] opay_r;

  logic [PIW-1:0] pi, free_idx, open_idx;
  logic           live_sel, free_any, fire;
  logic           do_open, do_push, do_pop, recv_ok, res_load;
  logic [1:0]     res_status;
  logic [5:0]     res_port;
  logic [CW-1:0]  res_cnt;
  logic [AW-1:0]  slot_w, slot_r;
  logic [PW-1:0]  wptr_inc, rptr_inc;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  logic           pay_we;
  logic [AW-1:0]  pay_waddr;
  logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;

  assign pi       = q_data.port[PIW-1:0];
  assign live_sel = q_data.port_ok && live_r[pi];
  assign fire     = (state_r == S_RUN) && q_valid && (!ovalid_r || out_bus.ready);
  assign q_pop    = fire;
  assign slot_w   = AW'(pi) * AW'(QUEUE_DEPTH) + AW'(wptr_r[pi]);
  assign slot_r   = AW'(pi) * AW'(QUEUE_DEPTH) + AW'(rptr_r[pi]);
  assign wptr_inc = (wptr_r[pi] == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r[pi] + 1'b1;
  assign rptr_inc = (rptr_r[pi] == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r[pi] + 1'b1;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NUM_PORTS - 1; i >= 0; i--) begin
      if (!live_r[i]) begin
        free_any = 1'b1;
        free_idx = PIW'(i);
      end
    end
  end

  always_comb begin
    res_status = ST_REJECT;
    res_port   = q_data.port;
    res_cnt    = '0;
    do_open    = 1'b0;
    open_idx   = pi;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    live_nxt   = live_r;
    case (q_data.command)
      OP_CREATE: begin
        if (q_data.port_ok && !live_r[pi]) begin
          do_open    = 1'b1;
          res_status = ST_OK;
        end
      end
      OP_CREATE_ANY: begin
        res_port = '0;
        if (free_any) begin
          do_open    = 1'b1;
          open_idx   = free_idx;
          res_port   = 6'(free_idx);
          res_status = ST_OK;
        end
      end
      OP_SEND, OP_NOTIFY: begin
        if (live_sel) begin
          res_cnt = cnt_r[pi];
          if (cnt_r[pi] >= CW'(QUEUE_DEPTH)) begin
            res_status = ST_FULL;
          end else begin
            do_push    = 1'b1;
            res_cnt    = cnt_r[pi] + 1'b1;
            res_status = ST_OK;
          end
        end
      end
      OP_RECV: begin
        if (live_sel && owner_r[pi] == q_data.pid) begin
          res_cnt = cnt_r[pi];
          if (cnt_r[pi] == '0) begin
            res_status = ST_EMPTY;
          end else begin
            do_pop     = 1'b1;
            res_cnt    = cnt_r[pi] - 1'b1;
            res_status = ST_OK;
          end
        end
      end
      OP_RELEASE: begin
        res_status = ST_OK;
        res_port   = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
          if (live_r[i] && owner_r[i] == q_data.pid) begin
            live_nxt[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (do_open) begin
      live_nxt[open_idx] = 1'b1;
    end
  end

  assign recv_ok  = fire && do_pop;
  assign res_load = fire && !do_pop;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (recv_ok) begin
          state_nxt = S_RDW;
        end
      end
      S_RDW:   state_nxt = S_RUN;
      default: state_nxt = S_CLR;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_bus.ready) begin
      ovalid_nxt = 1'b0;
    end
    if (res_load || state_r == S_RDW) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      live_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
      if (fire) begin
        live_r <= live_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_open) begin
      owner_r[open_idx] <= q_data.pid;
      rptr_r[open_idx]  <= '0;
      wptr_r[open_idx]  <= '0;
      cnt_r[open_idx]   <= '0;
    end
    if (fire && do_push) begin
      wptr_r[pi] <= wptr_inc;
      cnt_r[pi]  <= res_cnt;
    end
    if (recv_ok) begin
      rptr_r[pi] <= rptr_inc;
      cnt_r[pi]  <= res_cnt;
    end
    if (fire) begin
      ostatus_r <= res_status;
      oport_r   <= res_port;
      ocnt_r    <= res_cnt;
      ometa_r   <= '0;
      opay_r    <= '0;
    end
    if (state_r == S_RDW) begin
      ometa_r <= meta_rdata;
      opay_r  <= pay_rdata;
    end
  end

  assign meta_wdata = (q_data.command == OP_SEND)
                    ? {q_data.msg_from, q_data.msg_type, q_data.msg_len}
                    : {16'd0, q_data.msg_type, 8'd0};
  assign pay_we    = (state_r == S_CLR) || (fire && do_push && q_data.command == OP_SEND);
  assign pay_waddr = (state_r == S_CLR) ? clr_r : slot_w;
  assign pay_wdata = (state_r == S_CLR) ? '0 : q_data.msg_payload[PAYLOAD_BITS-1:0];

  omp_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_meta_ram (
    .clk   (clk),
    .we    (fire && do_push),
    .waddr (slot_w),
    .wdata (meta_wdata),
    .re    (recv_ok),
    .raddr (slot_r),
    .rdata (meta_rdata)
  );

  omp_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(DEPTH)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .re    (recv_ok),
    .raddr (slot_r),
    .rdata (pay_rdata)
  );

  assign out_bus.valid       = ovalid_r;
  assign out_bus.status      = ostatus_r;
  assign out_bus.port_id     = oport_r;
  assign out_bus.out_from    = ometa_r[55:40];
  assign out_bus.out_type    = ometa_r[39:8];
  assign out_bus.out_len     = ometa_r[7:0];
  assign out_bus.out_payload = 64'(opay_r);
  assign out_bus.queue_count = 4'(ocnt_r);

  assign stat.clearing = state_r == S_CLR;
  assign stat.rd_wait  = state_r == S_RDW;
endmodule

// ===== rtl/owned_message_port_mailbox.sv =====
// Top level of the owned message port mailbox.
//
// in_bus carries one command beat (create, create-any, send, receive, notify,
// release); out_bus returns exactly one result beat per command, in order.
// A two-entry command queue sits between the front end and the execution
// unit, and a result register sits on out_bus, so commands keep flowing
// while a result waits for the receiver.
// A successful receive passes through the wait state S_RDW after S_RUN, set by
// the registered read of the message store. A result is registered in the
// result register after the command has passed through the command queue;
// the execution unit takes one command per cycle while out_bus is not
// stalled, apart from a receive's wait state, in which it takes none.
// After reset all ports are free and the body-word store is swept to zero,
// one entry per cycle, over all NUM_PORTS * QUEUE_DEPTH entries; in_bus.ready
// stays low during the sweep. When out_bus stalls, the queue fills and
// in_bus.ready drops after at most two more beats.
`timescale 1ns / 1ps
module owned_message_port_mailbox #(
  parameter int NUM_PORTS    = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input logic        clk,
  input logic        rst_n,
  omp_in_if.sink     in_bus,
  omp_out_if.source  out_bus
);
  import omp_pkg::*;

  logic     push, q_full, q_valid, q_pop;
  cmd_t     push_data, q_head;
  bk_stat_t stat;

  omp_front #(.NUM_PORTS(NUM_PORTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .in_bus    (in_bus),
    .clearing  (stat.clearing),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  omp_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  omp_back #(
    .NUM_PORTS(NUM_PORTS), .QUEUE_DEPTH(QUEUE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .out_bus (out_bus),
    .stat    (stat)
  );

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_bus.ready)
    else $error("command accepted during store sweep");

  a_recv_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.rd_wait |=> out_bus.valid)
    else $error("receive wait did not produce a result");

  a_fail_no_body: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status != ST_OK |-> out_bus.out_payload == '0)
    else $error("failed command returned message data");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !q_pop)
    else $error("command executed during store sweep");
endmodule
